// File: rtl/core/vrlpd_pkg.sv
// Shared types and constants for the vertical run-length plane decoder.
// No dependencies; the parser, writer, top level, checker and testbench import it.
package vrlpd_pkg;

    localparam int MAX_ROWS_DEF      = 512;
    localparam int MAX_COLUMNS_DEF   = 64;
    localparam int PLANES            = 4;
    localparam int TABLE_ENTRIES     = 28;
    localparam int ROW_ADDR_MAX_W    = 12;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_FLAGS = 2'd1;
    localparam logic [1:0] CMD_BYTE  = 2'd2;
    localparam logic [1:0] CMD_TABLE = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FLAG = 2'd1;
    localparam logic [1:0] ST_CLIPPED = 2'd2;

    localparam logic [4:0] SRC_LITERAL = 5'd0;
    localparam logic [4:0] SRC_UP_LEFT = 5'd29;

    // One finished run, as handed from the parser to the write side.
    typedef struct packed {
        logic [1:0]                  plane_index;
        logic [5:0]                  column_index;
        logic [8:0]                  start_row;
        logic [7:0]                  first_value;
        logic [7:0]                  xor_step;
        logic [9:0]                  run_length;
        logic [1:0]                  status;
        logic                        image_done;
        logic                        bank;
        logic [ROW_ADDR_MAX_W-1:0]   wr_row;
    } run_t;

endpackage

// File: rtl/core/vrlpd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vrlpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/vrlpd_fifo.sv
// Two-entry queue between the token parser and the column writer.
// Depends on nothing; carries an opaque word.
module vrlpd_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/core/vrlpd_front.sv
// Token parser: takes flag words, table entries and stream bytes, tracks the
// position and emits one run descriptor per token or per flagless byte. Uses vrlpd_pkg.
module vrlpd_front #(
    parameter int MAX_ROWS    = vrlpd_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLUMNS = vrlpd_pkg::MAX_COLUMNS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  command,
    input  logic [15:0]                 value,
    input  logic [4:0]                  table_index,
    input  logic [6:0]                  columns_per_plane,
    input  logic [9:0]                  rows_per_column,
    input  logic                        q_full,
    input  logic                        back_quiet,
    output logic                        push,
    output vrlpd_pkg::run_t             push_run,
    output logic [$clog2(MAX_ROWS):0]   rd_addr,
    input  logic [7:0]                  rd_data
);
    import vrlpd_pkg::*;

    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CW  = $clog2(MAX_COLUMNS);
    localparam int SW  = ((RW + 1 > 10) ? RW + 1 : 10) + 1;
    localparam int CSW = ((CW + 1 > 7) ? CW + 1 : 7) + 1;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_DIFF  = 3'd1;
    localparam logic [2:0] PH_VALUE = 3'd2;
    localparam logic [2:0] PH_LEN1  = 3'd3;
    localparam logic [2:0] PH_LEN2  = 3'd4;

    logic [2:0]    phase_reg, phase_next;
    logic [7:0]    header_reg, header_next;
    logic [7:0]    diff_reg, diff_next;
    logic [7:0]    pvalue_reg, pvalue_next;
    logic [9:0]    plen_reg, plen_next;
    logic [15:0]   flags_reg, flags_next;
    logic [4:0]    left_reg, left_next;
    logic [1:0]    plane_reg, plane_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          bank_reg, bank_next;
    logic [RW:0]   fill_reg, fill_next;
    logic          wait_reg, wait_next;
    logic          nbok_reg, nbok_next;
    logic [7:0]    table_reg [TABLE_ENTRIES];

    logic          accept, step_en, nb_start;
    logic [SW-1:0] rows_e;
    logic [CSW-1:0] cols_e;

    always_comb
    begin
        rows_e = SW'(rows_per_column);
        if (rows_e == '0)
        begin
            rows_e = SW'(1);
        end
        else if (rows_e > SW'(MAX_ROWS))
        begin
            rows_e = SW'(MAX_ROWS);
        end
        cols_e = CSW'(columns_per_plane);
        if (cols_e == '0)
        begin
            cols_e = CSW'(1);
        end
        else if (cols_e > CSW'(MAX_COLUMNS))
        begin
            cols_e = CSW'(MAX_COLUMNS);
        end
    end

    always_comb
    begin
        logic [7:0]    b;
        logic          ad_go, ap_go, emit, nf;
        logic [7:0]    ap_val;
        logic [4:0]    src;
        logic [9:0]    e_len;
        logic [SW-1:0] row_w, remain, len_c, idx, endsum;
        logic          clip, col_end, done;
        b       = value[7:0];
        ad_go   = 1'b0;
        ap_go   = 1'b0;
        ap_val  = 8'd0;
        emit    = 1'b0;
        nf      = 1'b0;
        e_len   = 10'd0;
        nb_start = 1'b0;
        src     = 5'd0;
        idx     = '0;
        phase_next  = phase_reg;
        header_next = header_reg;
        diff_next   = diff_reg;
        pvalue_next = pvalue_reg;
        plen_next   = plen_reg;
        flags_next  = flags_reg;
        left_next   = left_reg;
        plane_next  = plane_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        bank_next   = bank_reg;
        fill_next   = fill_reg;
        wait_next   = 1'b0;
        nbok_next   = nbok_reg;

        if (wait_reg)
        begin
            ap_go  = 1'b1;
            ap_val = nbok_reg ? rd_data : 8'd0;
        end
        else if (command == CMD_FLAGS)
        begin
            flags_next = value;
            left_next  = 5'd16;
        end
        else if (command == CMD_BYTE)
        begin
            unique case (phase_reg)
                PH_DIFF:
                begin
                    diff_next = b;
                    ad_go     = 1'b1;
                end
                PH_VALUE:
                begin
                    ap_go  = 1'b1;
                    ap_val = b;
                end
                PH_LEN1:
                begin
                    if (b == 8'd0 || b == 8'd1)
                    begin
                        plen_next  = (b == 8'd0) ? 10'd256 : 10'd512;
                        phase_next = PH_LEN2;
                    end
                    else
                    begin
                        emit  = 1'b1;
                        e_len = 10'(b);
                    end
                end
                PH_LEN2:
                begin
                    emit  = 1'b1;
                    e_len = plen_reg + 10'(b);
                end
                default:
                begin
                    if (left_reg == 5'd0)
                    begin
                        nf = 1'b1;
                    end
                    else
                    begin
                        flags_next = {flags_reg[14:0], 1'b0};
                        left_next  = left_reg - 5'd1;
                        diff_next  = 8'd0;
                        plen_next  = 10'd0;
                        if (!flags_reg[15])
                        begin
                            pvalue_next = b;
                            emit        = 1'b1;
                            e_len       = 10'd1;
                        end
                        else
                        begin
                            header_next = b;
                            pvalue_next = 8'd0;
                            if (b[7])
                            begin
                                phase_next = PH_DIFF;
                            end
                            else
                            begin
                                ad_go = 1'b1;
                            end
                        end
                    end
                end
            endcase
        end

        if (ad_go)
        begin
            src = header_next[4:0];
            if (src == SRC_LITERAL)
            begin
                phase_next = PH_VALUE;
            end
            else if (src >= SRC_UP_LEFT)
            begin
                // Previous-column reference: read the store, finish next cycle.
                nb_start  = 1'b1;
                wait_next = 1'b1;
                idx = SW'(row_reg) + SW'(src) - SW'(SRC_UP_LEFT) - SW'(1);
                nbok_next = (col_reg != '0) && !(src == SRC_UP_LEFT && row_reg == '0)
                            && (idx < rows_e) && (idx < SW'(fill_reg));
            end
            else
            begin
                ap_go  = 1'b1;
                ap_val = table_reg[src - 5'd1];
            end
        end

        if (ap_go)
        begin
            pvalue_next = ap_val;
            if (header_next[6:5] != 2'd0)
            begin
                emit  = 1'b1;
                e_len = 10'(header_next[6:5]) + 10'd1;
            end
            else
            begin
                phase_next = PH_LEN1;
            end
        end

        row_w  = SW'(row_reg);
        remain = (row_w < rows_e) ? rows_e - row_w : SW'(1);
        clip   = SW'(e_len) > remain;
        len_c  = clip ? remain : SW'(e_len);
        endsum = row_w + len_c;
        col_end = endsum >= rows_e;
        done   = col_end && (CSW'(col_reg) + CSW'(1) >= cols_e)
                 && (plane_reg == 2'(PLANES - 1));

        push_run.plane_index  = plane_reg;
        push_run.column_index = 6'(col_reg);
        push_run.start_row    = 9'(row_reg);
        push_run.first_value  = nf ? b : pvalue_next;
        push_run.xor_step     = nf ? 8'd0 : diff_next;
        push_run.run_length   = nf ? 10'd0 : 10'(len_c);
        push_run.status       = nf ? ST_NO_FLAG : (clip ? ST_CLIPPED : ST_OK);
        push_run.image_done   = nf ? 1'b0 : done;
        push_run.bank         = bank_reg;
        push_run.wr_row       = ROW_ADDR_MAX_W'(row_reg);
        push = step_en && (emit || nf);

        if (emit)
        begin
            phase_next = PH_IDLE;
            if (col_end)
            begin
                row_next  = '0;
                bank_next = ~bank_reg;
                fill_next = (RW + 1)'(endsum);
                if (CSW'(col_reg) + CSW'(1) >= cols_e)
                begin
                    col_next   = '0;
                    plane_next = (plane_reg == 2'(PLANES - 1)) ? 2'd0 : plane_reg + 2'd1;
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
            end
            else
            begin
                row_next = RW'(endsum);
            end
        end

        if (!wait_reg && command == CMD_START)
        begin
            phase_next  = PH_IDLE;
            header_next = 8'd0;
            diff_next   = 8'd0;
            pvalue_next = 8'd0;
            plen_next   = 10'd0;
            flags_next  = 16'd0;
            left_next   = 5'd0;
            plane_next  = 2'd0;
            col_next    = '0;
            row_next    = '0;
            fill_next   = '0;
        end

        rd_addr = {~bank_reg, RW'(idx)};
    end

    assign in_ready = !wait_reg && !q_full && (!nb_start || back_quiet);
    assign accept   = in_valid && in_ready;
    assign step_en  = accept || wait_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            header_reg <= 8'd0;
            diff_reg   <= 8'd0;
            pvalue_reg <= 8'd0;
            plen_reg   <= 10'd0;
            flags_reg  <= 16'd0;
            left_reg   <= 5'd0;
            plane_reg  <= 2'd0;
            col_reg    <= '0;
            row_reg    <= '0;
            bank_reg   <= 1'b0;
            fill_reg   <= '0;
            wait_reg   <= 1'b0;
            nbok_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg  <= phase_next;
            header_reg <= header_next;
            diff_reg   <= diff_next;
            pvalue_reg <= pvalue_next;
            plen_reg   <= plen_next;
            flags_reg  <= flags_next;
            left_reg   <= left_next;
            plane_reg  <= plane_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            bank_reg   <= bank_next;
            fill_reg   <= fill_next;
            wait_reg   <= wait_next;
            nbok_reg   <= nbok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !wait_reg && command == CMD_TABLE && table_index < 5'(TABLE_ENTRIES))
        begin
            table_reg[table_index] <= value[7:0];
        end
    end

endmodule

// File: rtl/core/vrlpd_back.sv
// Column writer: pops run descriptors, presents them on the output register
// and writes the run's rows into the column store. Uses vrlpd_pkg.
module vrlpd_back #(
    parameter int MAX_ROWS = vrlpd_pkg::MAX_ROWS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_empty,
    input  vrlpd_pkg::run_t            q_run,
    output logic                       pop,
    output logic                       busy,
    output logic                       out_valid,
    input  logic                       out_ready,
    output vrlpd_pkg::run_t            out_run,
    output logic                       we,
    output logic [$clog2(MAX_ROWS):0]  waddr,
    output logic [7:0]                 wdata
);
    import vrlpd_pkg::*;

    localparam int RW = $clog2(MAX_ROWS);

    logic          valid_reg, valid_next;
    run_t          run_reg;
    logic          busy_reg, busy_next;
    logic          bank_reg;
    logic [RW-1:0] addr_reg, addr_next;
    logic [7:0]    val_reg, val_next;
    logic [7:0]    step_reg;
    logic [9:0]    cnt_reg, cnt_next;

    assign pop       = !busy_reg && !q_empty && (!valid_reg || out_ready);
    assign busy      = busy_reg;
    assign out_valid = valid_reg;
    assign out_run   = run_reg;
    assign we        = busy_reg;
    assign waddr     = {bank_reg, addr_reg};
    assign wdata     = val_reg;

    always_comb
    begin
        valid_next = valid_reg && !out_ready;
        busy_next  = busy_reg;
        addr_next  = addr_reg;
        val_next   = val_reg;
        cnt_next   = cnt_reg;
        if (busy_reg)
        begin
            addr_next = addr_reg + RW'(1);
            val_next  = val_reg ^ step_reg;
            cnt_next  = cnt_reg - 10'd1;
            busy_next = (cnt_reg != 10'd1);
        end
        if (pop)
        begin
            valid_next = 1'b1;
            busy_next  = (q_run.run_length != 10'd0);
            addr_next  = RW'(q_run.wr_row);
            val_next   = q_run.first_value;
            cnt_next   = q_run.run_length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            busy_reg  <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        val_reg  <= val_next;
        cnt_reg  <= cnt_next;
        if (pop)
        begin
            run_reg  <= q_run;
            bank_reg <= q_run.bank;
            step_reg <= q_run.xor_step;
        end
    end

endmodule

// File: rtl/core/vertical_run_length_plane_decoder.sv
// Top level of the vertical run-length plane decoder: parser, queue, writer
// and the two-bank column store. Uses vrlpd_pkg and the vrlpd_* modules.
//
//  Channel   Dir  Content
//  s_axis    in   tdata = value, table_index; tuser = command
//  m_axis    out  tdata = plane..run_length; tuser = status; tlast = image_done
//  cfg       in   cfg_index 0 columns_per_plane, 1 rows_per_column
//
// The parser takes a command or byte whenever it is ready; a previous-column
// pattern reference first waits until all earlier runs are written and then
// reads the column store in a wait state. The writer picks up a run once its
// output register is free and then stores one row per cycle, taking no new run
// until the last row is written; the input stalls while the queue is full.
// Reset clears all control state; the column store needs no clearing pass.
module vertical_run_length_plane_decoder #(
    parameter int MAX_ROWS    = vrlpd_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLUMNS = vrlpd_pkg::MAX_COLUMNS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // value[15:0], table_index[20:16]
    input  logic [1:0]  s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // plane_index, column_index, start_row,
                                        // first_value, xor_step, run_length
    output logic [1:0]  m_axis_tuser,   // status
    output logic        m_axis_tlast,   // image_done
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [9:0]  cfg_data
);
    import vrlpd_pkg::*;

    localparam int RW = $clog2(MAX_ROWS);
    localparam logic CFG_COLUMNS = 1'b0;

    logic [6:0]  cols_reg;
    logic [9:0]  rows_reg;
    logic        q_full, q_empty, push, pop, busy, we;
    run_t        push_run, q_run, out_run;
    logic [RW:0] rd_addr, waddr;
    logic [7:0]  rd_data, wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= 7'd64;
            rows_reg <= 10'd512;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_COLUMNS)
            begin
                cols_reg <= cfg_data[6:0];
            end
            else
            begin
                rows_reg <= cfg_data;
            end
        end
    end

    vrlpd_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS)) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (s_axis_tvalid),
        .in_ready          (s_axis_tready),
        .command           (s_axis_tuser),
        .value             (s_axis_tdata[15:0]),
        .table_index       (s_axis_tdata[20:16]),
        .columns_per_plane (cols_reg),
        .rows_per_column   (rows_reg),
        .q_full            (q_full),
        .back_quiet        (q_empty && !busy),
        .push              (push),
        .push_run          (push_run),
        .rd_addr           (rd_addr),
        .rd_data           (rd_data)
    );

    vrlpd_fifo #(.WIDTH($bits(run_t))) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_run),
        .pop       (pop),
        .pop_data  (q_run),
        .full      (q_full),
        .empty     (q_empty)
    );

    vrlpd_back #(.MAX_ROWS(MAX_ROWS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_run     (q_run),
        .pop       (pop),
        .busy      (busy),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_run   (out_run),
        .we        (we),
        .waddr     (waddr),
        .wdata     (wdata)
    );

    vrlpd_ram #(.WIDTH(8), .DEPTH(2 * MAX_ROWS)) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign m_axis_tdata = {5'd0, out_run.run_length, out_run.xor_step, out_run.first_value,
                           out_run.start_row, out_run.column_index, out_run.plane_index};
    assign m_axis_tuser = out_run.status;
    assign m_axis_tlast = out_run.image_done;

endmodule

// File: rtl/core/vrlpd_checker.sv
// Port-level checks for the plane decoder, bound to the top level.
// Uses vrlpd_pkg for the status codes.
module vrlpd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import vrlpd_pkg::*;

    // A dropped byte never carries a run or ends the image.
    a_noflag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ST_NO_FLAG |->
            m_axis_tdata[42:33] == 10'd0 && !m_axis_tlast)
        else $error("no-flag word carries a run");

    // Every real run writes at least one row.
    a_runlen: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != ST_NO_FLAG |-> m_axis_tdata[42:33] != 10'd0)
        else $error("empty run");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word dropped while stalled");

endmodule

bind vertical_run_length_plane_decoder vrlpd_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: tb/sv/tb_vertical_run_length_plane_decoder.sv
// Self-checking testbench for the vertical run-length plane decoder.
// Drives token streams through the input stream, predicts every run descriptor
// in a behavioral model of its own, and compares the output stream. Uses vrlpd_pkg.
module tb_vertical_run_length_plane_decoder;
    timeunit 1ns;
    timeprecision 1ps;
    import vrlpd_pkg::*;

    localparam int ROWS_CAP   = 512;
    localparam int COLS_CAP   = 64;
    localparam int IDX_COLS   = 0;
    localparam int IDX_ROWS   = 1;
    localparam int DRAIN_WAIT = 700;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [1:0]  cmd;
        logic [15:0] value;
        logic [4:0]  slot;
    } stream_item_t;

    typedef struct {
        logic [1:0] plane;
        logic [5:0] column;
        logic [8:0] row;
        logic [7:0] first;
        logic [7:0] step;
        logic [9:0] len;
        logic [1:0] status;
        logic       done;
    } run_desc_t;

    typedef enum int {PARSE_IDLE, PARSE_DIFF, PARSE_VALUE, PARSE_LEN1, PARSE_LEN2}
        parse_state_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_we;
    logic        cfg_index;
    logic [9:0]  cfg_data;

    vertical_run_length_plane_decoder dut (.*);

    // Decoder image of the block.
    logic [6:0]   cols_reg;
    logic [9:0]   rows_reg;
    parse_state_t parse_state;
    logic [7:0]   hdr;
    logic [7:0]   diff_byte;
    logic [7:0]   value_byte;
    int           len_base;
    logic [15:0]  flag_word;
    int           flag_count;
    int           plane_pos;
    int           column_pos;
    int           row_pos;
    logic [7:0]   pattern_slots [TABLE_ENTRIES];
    logic [7:0]   prev_col [ROWS_CAP];
    logic [7:0]   cur_col [ROWS_CAP];

    stream_item_t pending_words[$];
    run_desc_t    expected_runs[$];
    stream_item_t drive_item;

    bit     in_fire;
    bit     out_fire;
    int     send_gap;
    int     recv_stall;
    int     hold_left;
    bit     recv_idle_on;
    bit     send_idle_on;
    int     fail_count;
    longint cycle_count;
    int     runs_seen;
    int     clipped_seen;
    int     noflag_seen;
    int     done_seen;

    function automatic int rows_eff();
        if (rows_reg == 0)
            return 1;
        if (rows_reg > ROWS_CAP)
            return ROWS_CAP;
        return rows_reg;
    endfunction

    function automatic int cols_eff();
        if (cols_reg == 0)
            return 1;
        if (cols_reg > COLS_CAP)
            return COLS_CAP;
        return cols_reg;
    endfunction

    task automatic clear_image();
        parse_state = PARSE_IDLE;
        hdr = 0;
        diff_byte = 0;
        value_byte = 0;
        len_base = 0;
        flag_word = 0;
        flag_count = 0;
        plane_pos = 0;
        column_pos = 0;
        row_pos = 0;
        for (int i = 0; i < ROWS_CAP; i++)
        begin
            prev_col[i] = 0;
            cur_col[i] = 0;
        end
    endtask

    task automatic push_run(logic [7:0] first, logic [7:0] step, int len,
                            logic [1:0] st, bit done);
        run_desc_t r;
        r.plane = plane_pos[1:0];
        r.column = column_pos[5:0];
        r.row = row_pos[8:0];
        r.first = first;
        r.step = step;
        r.len = len[9:0];
        r.status = st;
        r.done = done;
        expected_runs.insert(expected_runs.size(), r);
    endtask

    // Previous-column byte next to the current row; zero outside the column.
    function automatic logic [7:0] side_byte(int delta);
        int idx;
        if (column_pos == 0)
            return 0;
        if (delta < 0 && row_pos == 0)
            return 0;
        idx = row_pos + delta;
        if (idx >= rows_eff() || idx >= ROWS_CAP)
            return 0;
        return prev_col[idx];
    endfunction

    task automatic finish_run(int len_in);
        int rows;
        int len;
        int remain;
        logic [1:0] st;
        bit done;
        logic [7:0] v;
        rows = rows_eff();
        len = len_in;
        remain = (row_pos < rows) ? rows - row_pos : 1;
        st = ST_OK;
        done = 0;
        v = value_byte;
        if (len > remain)
        begin
            len = remain;
            st = ST_CLIPPED;
        end
        for (int i = 0; i < len; i++)
        begin
            if (row_pos + i < ROWS_CAP)
                cur_col[row_pos + i] = v;
            v = v ^ diff_byte;
        end
        if (row_pos + len >= rows && column_pos + 1 >= cols_eff() && plane_pos == PLANES - 1)
            done = 1;
        push_run(value_byte, diff_byte, len, st, done);
        if (row_pos + len >= rows)
        begin
            prev_col = cur_col;
            for (int i = 0; i < ROWS_CAP; i++)
                cur_col[i] = 0;
            row_pos = 0;
            column_pos++;
            if (column_pos >= cols_eff())
            begin
                column_pos = 0;
                plane_pos = (plane_pos == PLANES - 1) ? 0 : plane_pos + 1;
            end
        end
        else
            row_pos = row_pos + len;
        parse_state = PARSE_IDLE;
    endtask

    task automatic after_source();
        int l;
        l = (hdr & 8'h60) >> 5;
        if (l != 0)
            finish_run(l + 1);
        else
            parse_state = PARSE_LEN1;
    endtask

    task automatic resolve_source();
        int src;
        src = hdr & 8'h1f;
        if (src == SRC_LITERAL)
        begin
            parse_state = PARSE_VALUE;
            return;
        end
        if (src == SRC_UP_LEFT)
            value_byte = side_byte(-1);
        else if (src == SRC_UP_LEFT + 1)
            value_byte = side_byte(0);
        else if (src == SRC_UP_LEFT + 2)
            value_byte = side_byte(1);
        else
            value_byte = pattern_slots[src - 1];
        after_source();
    endtask

    task automatic decode_byte(logic [7:0] b);
        bit is_run;
        case (parse_state)
            PARSE_DIFF:
            begin
                diff_byte = b;
                resolve_source();
            end
            PARSE_VALUE:
            begin
                value_byte = b;
                after_source();
            end
            PARSE_LEN1:
            begin
                if (b == 0)
                begin
                    len_base = 256;
                    parse_state = PARSE_LEN2;
                end
                else if (b == 1)
                begin
                    len_base = 512;
                    parse_state = PARSE_LEN2;
                end
                else
                    finish_run(b);
            end
            PARSE_LEN2:
                finish_run(len_base + b);
            default:
            begin
                if (flag_count == 0)
                    push_run(b, 0, 0, ST_NO_FLAG, 0);
                else
                begin
                    is_run = flag_word[15];
                    flag_word = flag_word << 1;
                    flag_count--;
                    diff_byte = 0;
                    len_base = 0;
                    if (!is_run)
                    begin
                        value_byte = b;
                        finish_run(1);
                    end
                    else
                    begin
                        hdr = b;
                        value_byte = 0;
                        if (b[7])
                            parse_state = PARSE_DIFF;
                        else
                            resolve_source();
                    end
                end
            end
        endcase
    endtask

    task automatic predict_word(stream_item_t it);
        case (it.cmd)
            CMD_START:
                clear_image();
            CMD_FLAGS:
            begin
                flag_word = it.value;
                flag_count = 16;
            end
            CMD_TABLE:
                if (it.slot < TABLE_ENTRIES)
                    pattern_slots[it.slot] = it.value[7:0];
            default:
                decode_byte(it.value[7:0]);
        endcase
    endtask

    task automatic queue_word(logic [1:0] cmd, logic [15:0] value, logic [4:0] slot);
        stream_item_t it;
        it.cmd = cmd;
        it.value = value;
        it.slot = slot;
        pending_words.insert(pending_words.size(), it);
    endtask

    // One flag word followed by well-formed tokens with random content.
    task automatic queue_token_group(int n, int max_len_byte);
        logic [15:0] flags;
        logic [7:0]  h;
        int          l;
        int          lb;
        flags = 16'($urandom);
        queue_word(CMD_FLAGS, flags, 5'($urandom_range(0, 31)));
        for (int t = 0; t < n; t++)
        begin
            if (!flags[15 - t])
                queue_word(CMD_BYTE, 16'($urandom_range(0, 255)), 0);
            else
            begin
                h = 8'($urandom);
                if ($urandom_range(0, 3) == 0)
                    h[4:0] = 5'(SRC_UP_LEFT + $urandom_range(0, 2));
                queue_word(CMD_BYTE, {8'($urandom_range(0, 255)), h},
                           5'($urandom_range(0, 31)));
                if (h[7])
                    queue_word(CMD_BYTE, 16'($urandom_range(0, 255)), 0);
                if (h[4:0] == SRC_LITERAL)
                    queue_word(CMD_BYTE, 16'($urandom_range(0, 255)), 0);
                l = int'(h[6:5]);
                if (l == 0)
                begin
                    lb = int'($urandom_range(0, max_len_byte));
                    queue_word(CMD_BYTE, 16'(lb), 0);
                    if (lb < 2)
                        queue_word(CMD_BYTE, 16'($urandom_range(0, 255)), 0);
                end
            end
        end
    endtask

    task automatic queue_noise();
        case ($urandom_range(0, 5))
            0: queue_word(CMD_START, 16'($urandom), 5'($urandom_range(0, 31)));
            1: queue_word(CMD_TABLE, 16'($urandom), 5'($urandom_range(0, 31)));
            2: queue_word(CMD_FLAGS, 16'($urandom), 5'($urandom_range(0, 31)));
            default: queue_word(CMD_BYTE, 16'($urandom), 5'($urandom_range(0, 31)));
        endcase
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || s_axis_tvalid || expected_runs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(int index, int data);
        @(negedge clk);
        cfg_we = 1;
        cfg_index = index[0];
        cfg_data = data[9:0];
        if (index == IDX_COLS)
            cols_reg = data[6:0];
        else
            rows_reg = data[9:0];
        @(negedge clk);
        cfg_we = 0;
    endtask

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Sender: presents one word at a time, with a random gap after each while gaps are enabled.
    always @(negedge clk)
    begin
        if (s_axis_tvalid && !in_fire)
        begin
        end
        else if (send_gap > 0)
        begin
            send_gap <= send_gap - 1;
            s_axis_tvalid <= 0;
        end
        else if (pending_words.size() != 0)
        begin
            drive_item = pending_words.pop_front();
            s_axis_tdata <= {3'b0, drive_item.slot, drive_item.value};
            s_axis_tuser <= drive_item.cmd;
            s_axis_tvalid <= 1;
            send_gap <= send_idle_on ? int'($urandom_range(0, 13)) : 0;
        end
        else
            s_axis_tvalid <= 0;
    end

    // Receiver: random stalls, plus the long hold-off when requested.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 0;
        end
        else if (recv_stall > 0)
        begin
            recv_stall <= recv_stall - 1;
            m_axis_tready <= 0;
        end
        else
        begin
            m_axis_tready <= 1;
            if (out_fire && recv_idle_on)
                recv_stall <= int'($urandom_range(0, 13));
        end
    end

    always @(posedge clk)
    begin
        run_desc_t e;
        in_fire = s_axis_tvalid && s_axis_tready;
        out_fire = m_axis_tvalid && m_axis_tready;
        cycle_count++;
        if (in_fire)
            predict_word(drive_item);
        if (out_fire)
        begin
            runs_seen++;
            if (m_axis_tuser == ST_CLIPPED)
                clipped_seen++;
            if (m_axis_tuser == ST_NO_FLAG)
                noflag_seen++;
            if (m_axis_tlast)
                done_seen++;
            if (expected_runs.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected word, expected none, actual tdata=%h tuser=%0d tlast=%0b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
            else
            begin
                e = expected_runs.pop_front();
                if (m_axis_tdata !== {5'b0, e.len, e.step, e.first, e.row, e.column, e.plane}
                    || m_axis_tuser !== e.status || m_axis_tlast !== e.done)
                begin
                    fail_count++;
                    $display({"%0t: mismatch, expected plane=%0d col=%0d row=%0d ",
                              "first=%h step=%h len=%0d st=%0d done=%0b"},
                             $time, e.plane, e.column, e.row, e.first, e.step, e.len,
                             e.status, e.done);
                    $display({"%0t:           actual plane=%0d col=%0d row=%0d ",
                              "first=%h step=%h len=%0d st=%0d done=%0b"},
                             $time, m_axis_tdata[1:0], m_axis_tdata[7:2], m_axis_tdata[16:8],
                             m_axis_tdata[24:17], m_axis_tdata[32:25], m_axis_tdata[42:33],
                             m_axis_tuser, m_axis_tlast);
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int col_set [8] = '{2, 1, 0, 3, 64, 127, 5, 4};
        int row_set [8] = '{6, 1, 0, 512, 4, 1023, 17, 9};
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        s_axis_tuser = 0;
        m_axis_tready = 0;
        cfg_we = 0;
        cfg_index = 0;
        cfg_data = 0;
        send_gap = 0;
        recv_stall = 0;
        hold_left = 0;
        recv_idle_on = 1;
        send_idle_on = 1;
        fail_count = 0;
        cycle_count = 0;
        runs_seen = 0;
        clipped_seen = 0;
        noflag_seen = 0;
        done_seen = 0;
        cols_reg = 64;
        rows_reg = 512;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            pattern_slots[i] = 0;
        clear_image();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        write_reg(IDX_COLS, 2);
        write_reg(IDX_ROWS, 8);
        // The whole pattern table is loaded before any table reference.
        for (int i = 0; i < TABLE_ENTRIES; i++)
            queue_word(CMD_TABLE, 16'($urandom), 5'(i));
        // Directed: a byte with no flags, out-of-range slot, all header kinds.
        queue_word(CMD_BYTE, 16'h00ff, 0);
        queue_word(CMD_TABLE, 16'hffff, 31);
        queue_word(CMD_FLAGS, 16'h7fff, 0);
        queue_word(CMD_BYTE, 16'h00a5, 0);          // single value
        queue_word(CMD_BYTE, 16'h00e0, 0);          // diff and literal follow, 4 rows
        queue_word(CMD_BYTE, 16'h00ff, 0);
        queue_word(CMD_BYTE, 16'h0000, 0);
        queue_word(CMD_BYTE, 16'h00ff, 0);          // down-left with diff: clipped
        queue_word(CMD_BYTE, 16'h0001, 0);
        queue_word(CMD_BYTE, 16'h003c, 0);          // 2 rows from table slot 27
        queue_word(CMD_BYTE, 16'h007d, 0);          // up-left, 4 rows
        queue_word(CMD_BYTE, 16'h005e, 0);          // left, 3 rows
        queue_word(CMD_BYTE, 16'h003f, 0);          // down-left, 2 rows
        queue_word(CMD_BYTE, 16'h0001, 0);          // table slot 0, length byte
        queue_word(CMD_BYTE, 16'h0002, 0);
        queue_word(CMD_FLAGS, 16'hffff, 0);         // flag reload
        queue_word(CMD_START, 16'h0000, 0);
        wait_idle();

        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(IDX_COLS, col_set[ph]);
            write_reg(IDX_ROWS, row_set[ph]);
            recv_idle_on = (ph != 2);
            send_idle_on = (ph != 4);
            if (ph == 1)
                hold_left = 3000;
            while (pending_words.size() < 100)
            begin
                if ($urandom_range(0, 9) == 0)
                    queue_noise();
                else
                    queue_token_group($urandom_range(1, 16), row_set[ph] > 64 ? 255 : 12);
            end
            wait_idle();
        end

        $display("Covered %0d run words: %0d clipped, %0d without a flag, %0d image ends.",
                 runs_seen, clipped_seen, noflag_seen, done_seen);
        $display("Register settings included the width and height extremes and zero.");
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
